### hdl/pap_pkg.sv
// Package for the polygon area and perimeter block.
// Holds the fixed result widths, result types and saturation limits.
// No dependencies; compile this file first.
package pap_pkg;

  // Result widths are fixed by the output format.
  localparam int PERIM_W     = 27;
  localparam int AREA_W      = 32;
  localparam int CROSS_W     = 64;
  // Integer part kept in the perimeter sum: one bit above the result width.
  localparam int PERIM_INT_W = PERIM_W + 1;

  typedef logic [PERIM_W-1:0]        perim_t;
  typedef logic [AREA_W-1:0]         area_t;
  typedef logic signed [CROSS_W-1:0] cross_t;

  localparam perim_t PERIM_MAX     = '1;
  localparam area_t  AREA_MAX      = '1;
  localparam cross_t CROSS_POS_MAX = {1'b0, {(CROSS_W-1){1'b1}}};
  localparam cross_t CROSS_NEG_MAX = {1'b1, {(CROSS_W-1){1'b0}}};

endpackage

### hdl/pap_if.sv
// Channel interfaces of the polygon area and perimeter block.
// pap_in_if carries vertices, pap_out_if carries results.
// Depends on pap_pkg for the result types.
interface pap_in_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vx;
  logic signed [COORD_BITS-1:0] vy;
  logic                         is_last;

  modport source (output valid, vx, vy, is_last, input ready);
  modport sink   (input valid, vx, vy, is_last, output ready);
endinterface

interface pap_out_if;
  logic            valid;
  logic            ready;
  pap_pkg::perim_t perimeter;
  pap_pkg::area_t  area;

  modport source (output valid, perimeter, area, input ready);
  modport sink   (input valid, perimeter, area, output ready);
endinterface

### hdl/pap_mac.sv
// Serial multiply-accumulate unit: sums two signed products a0*b0 and a1*b1,
// one multiplier bit of each per cycle, operands given as magnitude and sign.
// Depends on nothing but the clock and reset.
module pap_mac #(
  parameter int MAG_W = 17
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [MAG_W-1:0]         a0,
  input  logic [MAG_W-1:0]         b0,
  input  logic                     neg0,
  input  logic [MAG_W-1:0]         a1,
  input  logic [MAG_W-1:0]         b1,
  input  logic                     neg1,
  output logic                     done,
  output logic signed [2*MAG_W:0]  prod
);

  localparam int PROD_W = 2 * MAG_W + 1;
  localparam int CNT_W  = $clog2(MAG_W + 1);
  localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(MAG_W);

  logic [2*MAG_W-1:0]        a0_r, a1_r;
  logic [MAG_W-1:0]          b0_r, b1_r;
  logic                      neg0_r, neg1_r;
  logic signed [PROD_W-1:0]  acc_r, acc_nxt;
  logic signed [PROD_W-1:0]  part0, part1;
  logic [CNT_W-1:0]          cnt_r;
  logic                      busy_r, done_r;

  // Partial products of this cycle, negated where the product is negative.
  always_comb begin
    part0 = b0_r[0] ? $signed({1'b0, a0_r}) : '0;
    part1 = b1_r[0] ? $signed({1'b0, a1_r}) : '0;
    if (neg0_r) begin
      part0 = -part0;
    end
    if (neg1_r) begin
      part1 = -part1;
    end
    acc_nxt = acc_r + part0 + part1;
  end

  // Bit counter and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_LOAD;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operand shift registers and accumulator.
  always_ff @(posedge clk) begin
    if (start) begin
      a0_r   <= {{MAG_W{1'b0}}, a0};
      a1_r   <= {{MAG_W{1'b0}}, a1};
      b0_r   <= b0;
      b1_r   <= b1;
      neg0_r <= neg0;
      neg1_r <= neg1;
      acc_r  <= '0;
    end else if (busy_r) begin
      a0_r  <= {a0_r[2*MAG_W-2:0], 1'b0};
      a1_r  <= {a1_r[2*MAG_W-2:0], 1'b0};
      b0_r  <= {1'b0, b0_r[MAG_W-1:1]};
      b1_r  <= {1'b0, b1_r[MAG_W-1:1]};
      acc_r <= acc_nxt;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

### hdl/pap_sqrt.sv
// Digit-by-digit square root: one root bit per cycle, input pairs taken from
// the top of a shift register, then FRAC_BITS zero pairs for the fraction.
// Depends on nothing but the clock and reset.
module pap_sqrt #(
  parameter int MAG_W     = 17,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [2*MAG_W-1:0]            d,
  output logic                          done,
  output logic [MAG_W+FRAC_BITS-1:0]    root
);

  localparam int D_W    = 2 * MAG_W;
  localparam int ROOT_W = MAG_W + FRAC_BITS;
  localparam int REM_W  = ROOT_W + 1;
  localparam int WRK_W  = ROOT_W + 3;
  localparam int CNT_W  = $clog2(ROOT_W + 1);
  localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(ROOT_W);

  logic [D_W-1:0]    d_r;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [WRK_W-1:0]  rem_sh, trial, diff;
  logic              take;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r, done_r;

  // One trial subtraction per cycle.
  always_comb begin
    rem_sh   = {rem_r, d_r[D_W-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    diff     = rem_sh - trial;
    take     = (rem_sh >= trial);
    rem_nxt  = take ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
    root_nxt = {root_r[ROOT_W-2:0], take};
  end

  // Digit counter and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_LOAD;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Radicand shift register, remainder and partial root.
  always_ff @(posedge clk) begin
    if (start) begin
      d_r    <= d;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      d_r    <= {d_r[D_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

### hdl/polygon_area_perimeter.sv
// Top level of the polygon area and perimeter block: sequencer, accumulators
// and output register. Depends on pap_pkg, pap_if, pap_mac and pap_sqrt.
//
//   Channel   Direction  Payload                         Request taken when
//   in_if     sink       vx, vy (signed), is_last        valid && ready
//   out_if    source     perimeter (27b), area (32b)     valid && ready
//
// One vertex at a time. An edge runs through a set-up step, the multiply steps (one
// per magnitude bit) and the root digits (one per root bit), each followed by a
// hand-over step. A vertex blocks the input while the edge that it ends is worked; the
// last vertex also blocks it for the closing edge and for ST_FIN and ST_OUT. Reset is
// synchronous and clears the accumulators. A waiting result does not block the next
// vertex; a second result stalls in ST_OUT until the first is taken.
module polygon_area_perimeter #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  pap_in_if.sink     in_if,
  pap_out_if.source  out_if
);

  localparam int MAG_W  = COORD_BITS + 1;
  localparam int PROD_W = 2 * MAG_W + 1;
  localparam int ROOT_W = MAG_W + FRAC_BITS;
  localparam int LEN_W  = FRAC_BITS + pap_pkg::PERIM_INT_W;
  localparam int CW     = pap_pkg::CROSS_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_ROOT,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  state_t          state_r, state_nxt;
  logic            have_first_r, have_first_nxt;
  coord_t          first_x_r, first_x_nxt, first_y_r, first_y_nxt;
  coord_t          prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  coord_t          ax_r, ax_nxt, ay_r, ay_nxt, bx_r, bx_nxt, by_r, by_nxt;
  logic            last_r, last_nxt;
  logic            closing_r, closing_nxt;
  pap_pkg::cross_t cross_r, cross_nxt;
  logic [LEN_W-1:0] lsum_r, lsum_nxt;
  pap_pkg::perim_t per_r, per_nxt;
  logic [CW-1:0]   mag_r, mag_nxt;
  logic            out_valid_r, out_valid_nxt;
  pap_pkg::perim_t out_per_r, out_per_nxt;
  pap_pkg::area_t  out_area_r, out_area_nxt;

  logic            accept, out_free;
  logic            mac_start, mac_done, sq_done, cr_done;
  logic            sqrt_start, sqrt_done;
  logic signed [MAG_W-1:0]  dx, dy;
  logic [MAG_W-1:0]         udx, udy;
  logic [COORD_BITS-1:0]    ax_mag, ay_mag, bx_mag, by_mag;
  logic signed [PROD_W-1:0] sq_prod, cr_prod;
  logic [ROOT_W-1:0]        root;
  logic signed [CW:0]       cross_wide;
  pap_pkg::cross_t          cross_sat;
  logic [LEN_W:0]           lsum_wide;
  logic [LEN_W-1:0]         lsum_sat;
  logic [pap_pkg::PERIM_INT_W:0] per_wide;
  logic [CW-1:0]            area_wide;

  // Edge operands: coordinate differences for the length, magnitudes and
  // signs of the endpoints for the shoelace term.
  always_comb begin
    dx     = $signed({bx_r[COORD_BITS-1], bx_r}) - $signed({ax_r[COORD_BITS-1], ax_r});
    dy     = $signed({by_r[COORD_BITS-1], by_r}) - $signed({ay_r[COORD_BITS-1], ay_r});
    udx    = dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
    udy    = dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
    ax_mag = ax_r[COORD_BITS-1] ? COORD_BITS'(-ax_r) : COORD_BITS'(ax_r);
    ay_mag = ay_r[COORD_BITS-1] ? COORD_BITS'(-ay_r) : COORD_BITS'(ay_r);
    bx_mag = bx_r[COORD_BITS-1] ? COORD_BITS'(-bx_r) : COORD_BITS'(bx_r);
    by_mag = by_r[COORD_BITS-1] ? COORD_BITS'(-by_r) : COORD_BITS'(by_r);
  end

  assign mac_start  = (state_r == ST_SETUP);
  assign mac_done   = sq_done && cr_done;
  assign sqrt_start = (state_r == ST_MUL) && mac_done;

  // Squared edge length: dx*dx + dy*dy.
  pap_mac #(.MAG_W(MAG_W)) u_sq_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mac_start),
    .a0    (udx),
    .b0    (udx),
    .neg0  (1'b0),
    .a1    (udy),
    .b1    (udy),
    .neg1  (1'b0),
    .done  (sq_done),
    .prod  (sq_prod)
  );

  // Shoelace term: ax*by - bx*ay.
  pap_mac #(.MAG_W(MAG_W)) u_cr_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mac_start),
    .a0    ({1'b0, ax_mag}),
    .b0    ({1'b0, by_mag}),
    .neg0  (ax_r[COORD_BITS-1] ^ by_r[COORD_BITS-1]),
    .a1    ({1'b0, bx_mag}),
    .b1    ({1'b0, ay_mag}),
    .neg1  (~(bx_r[COORD_BITS-1] ^ ay_r[COORD_BITS-1])),
    .done  (cr_done),
    .prod  (cr_prod)
  );

  // Edge length with FRAC_BITS fraction bits.
  pap_sqrt #(.MAG_W(MAG_W), .FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .d     (sq_prod[2*MAG_W-1:0]),
    .done  (sqrt_done),
    .root  (root)
  );

  // Saturating accumulation of the shoelace and length sums.
  always_comb begin
    cross_wide = $signed({cross_r[CW-1], cross_r})
               + $signed({{(CW+1-PROD_W){cr_prod[PROD_W-1]}}, cr_prod});
    if (cross_wide[CW] != cross_wide[CW-1]) begin
      cross_sat = cross_wide[CW] ? pap_pkg::CROSS_NEG_MAX : pap_pkg::CROSS_POS_MAX;
    end else begin
      cross_sat = cross_wide[CW-1:0];
    end
    lsum_wide = {1'b0, lsum_r} + {{(LEN_W+1-ROOT_W){1'b0}}, root};
    lsum_sat  = lsum_wide[LEN_W] ? {LEN_W{1'b1}} : lsum_wide[LEN_W-1:0];
  end

  // Rounding of both results.
  always_comb begin
    per_wide  = {1'b0, lsum_r[LEN_W-1:FRAC_BITS]}
              + {{pap_pkg::PERIM_INT_W{1'b0}}, lsum_r[FRAC_BITS-1]};
    area_wide = {1'b0, mag_r[CW-1:1]} + {{(CW-1){1'b0}}, mag_r[0]};
  end

  assign accept   = in_if.valid && in_if.ready;
  assign out_free = !out_valid_r || out_if.ready;

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    have_first_nxt = have_first_r;
    first_x_nxt    = first_x_r;
    first_y_nxt    = first_y_r;
    prev_x_nxt     = prev_x_r;
    prev_y_nxt     = prev_y_r;
    ax_nxt         = ax_r;
    ay_nxt         = ay_r;
    bx_nxt         = bx_r;
    by_nxt         = by_r;
    last_nxt       = last_r;
    closing_nxt    = closing_r;
    cross_nxt      = cross_r;
    lsum_nxt       = lsum_r;
    per_nxt        = per_r;
    mag_nxt        = mag_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_per_nxt    = out_per_r;
    out_area_nxt   = out_area_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          prev_x_nxt = in_if.vx;
          prev_y_nxt = in_if.vy;
          last_nxt   = in_if.is_last;
          if (have_first_r) begin
            // Edge from the previous vertex to this one.
            ax_nxt      = prev_x_r;
            ay_nxt      = prev_y_r;
            bx_nxt      = in_if.vx;
            by_nxt      = in_if.vy;
            closing_nxt = 1'b0;
            state_nxt   = ST_SETUP;
          end else begin
            // First vertex: only a closing edge onto itself if it is also last.
            first_x_nxt    = in_if.vx;
            first_y_nxt    = in_if.vy;
            have_first_nxt = 1'b1;
            ax_nxt         = in_if.vx;
            ay_nxt         = in_if.vy;
            bx_nxt         = in_if.vx;
            by_nxt         = in_if.vy;
            closing_nxt    = 1'b1;
            if (in_if.is_last) begin
              state_nxt = ST_SETUP;
            end
          end
        end
      end
      ST_SETUP: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (mac_done) begin
          cross_nxt = cross_sat;
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (sqrt_done) begin
          lsum_nxt = lsum_sat;
          if (closing_r) begin
            state_nxt = ST_FIN;
          end else if (last_r) begin
            // Closing edge from the last vertex back to the first.
            ax_nxt      = prev_x_r;
            ay_nxt      = prev_y_r;
            bx_nxt      = first_x_r;
            by_nxt      = first_y_r;
            closing_nxt = 1'b1;
            state_nxt   = ST_SETUP;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_FIN: begin
        per_nxt   = (per_wide[pap_pkg::PERIM_INT_W:pap_pkg::PERIM_W] != '0)
                  ? pap_pkg::PERIM_MAX : per_wide[pap_pkg::PERIM_W-1:0];
        mag_nxt   = cross_r[CW-1] ? CW'(-cross_r) : CW'(cross_r);
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_per_nxt    = per_r;
          out_area_nxt   = (area_wide[CW-1:pap_pkg::AREA_W] != '0)
                         ? pap_pkg::AREA_MAX : area_wide[pap_pkg::AREA_W-1:0];
          have_first_nxt = 1'b0;
          cross_nxt      = '0;
          lsum_nxt       = '0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, accumulators and output register.
  always_ff @(posedge clk) begin
    first_x_r  <= first_x_nxt;
    first_y_r  <= first_y_nxt;
    prev_x_r   <= prev_x_nxt;
    prev_y_r   <= prev_y_nxt;
    ax_r       <= ax_nxt;
    ay_r       <= ay_nxt;
    bx_r       <= bx_nxt;
    by_r       <= by_nxt;
    last_r     <= last_nxt;
    closing_r  <= closing_nxt;
    per_r      <= per_nxt;
    mag_r      <= mag_nxt;
    out_per_r  <= out_per_nxt;
    out_area_r <= out_area_nxt;
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      have_first_r <= 1'b0;
      cross_r      <= '0;
      lsum_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      have_first_r <= have_first_nxt;
      cross_r      <= cross_nxt;
      lsum_r       <= lsum_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign in_if.ready      = (state_r == ST_IDLE);
  assign out_if.valid     = out_valid_r;
  assign out_if.perimeter = out_per_r;
  assign out_if.area      = out_area_r;

endmodule

### hdl/pap_check.sv
// Port-level checker for the polygon area and perimeter block, with the bind
// that attaches it to the top level. Depends on pap_pkg for the result types.
module pap_check (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            in_is_last,
  input logic            out_valid,
  input logic            out_ready,
  input pap_pkg::perim_t out_perimeter,
  input pap_pkg::area_t  out_area
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_perimeter) && $stable(out_area))
    else $error("result payload changed while stalled");

  // The closing vertex always keeps the block busy for the closing edge.
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_is_last |=> !in_ready)
    else $error("vertex taken straight after a closing vertex");

  // A result is only raised from the busy finishing step, never while idle.
  a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result raised while the block was idle");

endmodule

bind polygon_area_perimeter pap_check u_pap_check (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .in_is_last    (in_if.is_last),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .out_perimeter (out_if.perimeter),
  .out_area      (out_if.area)
);
